>>> sv/fbds_pkg.sv
// Package for the fractional baud divisor search unit.
// Holds widths, limits, the divider operand selector and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package fbds_pkg;

    localparam int PCLK_W    = 28;
    localparam int GOAL_W    = 22;
    localparam int DIV_W     = 16;
    localparam int FRAC_W    = 4;
    localparam int ERR_W     = 30;
    localparam int BEST_ERR_W = 31;
    localparam int WORD_W    = 32;

    localparam logic [DIV_W-1:0]  DIVISOR_MAX = 16'd65535;
    localparam logic [FRAC_W-1:0] FRAC_MAX    = 4'd15;
    localparam logic [FRAC_W-1:0] DV_MIN      = 4'd2;

    typedef enum logic [2:0] {
        DS_Q    = 3'd0,
        DS_FRAC = 3'd1,
        DS_BASE = 3'd2,
        DS_DV   = 3'd3,
        DS_BAUD = 3'd4
    } div_sel_t;

    typedef struct packed {
        logic     init;
        logic     start_div;
        logic     capture;
        div_sel_t div_sel;
        logic     set_bounds;
        logic     next_d;
        logic     clr_m;
        logic     next_m;
        logic     update_best;
        logic     load_out;
    } fbds_cmd_t;

    typedef struct packed {
        logic goal_zero;
        logic div_busy;
        logic div_done;
        logic empty;
        logic fden_zero;
        logic frac_zero;
        logic dv_ok;
        logic better;
        logic d_last;
        logic m_last;
        logic out_free;
    } fbds_stat_t;

endpackage
`default_nettype wire

>>> sv/fbds_if.sv
// Handshake interfaces for the fractional baud divisor search unit:
// request, result and configuration write channels. Uses fbds_pkg.
`default_nettype none
interface fbds_req_if;
    import fbds_pkg::*;
    logic              valid;
    logic              ready;
    logic [GOAL_W-1:0] goal_baud;
    modport source (output valid, output goal_baud, input ready);
    modport sink   (input valid, input goal_baud, output ready);
endinterface

interface fbds_rsp_if;
    import fbds_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIV_W-1:0]  divisor_latch;
    logic [FRAC_W-1:0] frac_multiplier;
    logic [FRAC_W-1:0] frac_divide_add;
    logic [ERR_W-1:0]  error_x256;
    logic              found;
    modport source (output valid, output divisor_latch, output frac_multiplier,
                    output frac_divide_add, output error_x256, output found,
                    input ready);
    modport sink   (input valid, input divisor_latch, input frac_multiplier,
                    input frac_divide_add, input error_x256, input found,
                    output ready);
endinterface

interface fbds_cfg_if;
    import fbds_pkg::*;
    logic              valid;
    logic              ready;
    logic [PCLK_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/fbds_div.sv
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Used by fbds_datapath. Depends on fbds_pkg.
`default_nettype none
module fbds_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fbds_pkg::WORD_W-1:0] dividend,
    input  wire logic [fbds_pkg::WORD_W-1:0] divisor,
    output logic                             busy,
    output logic                             done,
    output logic [fbds_pkg::WORD_W-1:0]      quotient
);
    import fbds_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[WORD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> sv/fbds_datapath.sv
// Datapath of the baud divisor search: search registers, operand muxes,
// shared divider, best-setting registers and the result register.
// Depends on fbds_pkg and fbds_div.
`default_nettype none
module fbds_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fbds_pkg::fbds_cmd_t         cmd,
    output fbds_pkg::fbds_stat_t             stat,
    input  wire logic                        cfg_we,
    input  wire logic [fbds_pkg::PCLK_W-1:0] cfg_data,
    input  wire logic [fbds_pkg::GOAL_W-1:0] goal_in,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [fbds_pkg::DIV_W-1:0]       out_divisor,
    output logic [fbds_pkg::FRAC_W-1:0]      out_mul,
    output logic [fbds_pkg::FRAC_W-1:0]      out_dadd,
    output logic [fbds_pkg::ERR_W-1:0]       out_err,
    output logic                             out_found
);
    import fbds_pkg::*;

    logic [PCLK_W-1:0]     pclk_reg;
    logic [GOAL_W-1:0]     goal_reg;
    logic [WORD_W-1:0]     q_reg, frac_reg, base_reg, dvq_reg, baud_reg;
    logic [DIV_W-1:0]      hi_reg;
    logic [DIV_W-1:0]      d_reg;
    logic [FRAC_W-1:0]     m_reg;
    logic [DIV_W-1:0]      best_d_reg;
    logic [FRAC_W-1:0]     best_m_reg, best_da_reg;
    logic [BEST_ERR_W-1:0] best_err_reg;
    logic                  found_reg;
    logic                  out_valid_reg;
    logic [DIV_W-1:0]      out_d_reg;
    logic [FRAC_W-1:0]     out_m_reg, out_da_reg;
    logic [ERR_W-1:0]      out_err_reg;
    logic                  out_found_reg;

    logic [WORD_W-1:0]     dvd, dsr, quo;
    logic                  div_busy, div_done;
    logic [37:0]           goal_d_prod;
    logic [35:0]           baud_prod;
    logic [28:0]           hi_raw;
    logic [DIV_W-1:0]      hi_val;
    logic [23:0]           lo_raw, lo_val;
    logic [WORD_W-1:0]     dv1k;
    logic [21:0]           dv;
    logic [4:0]            m_plus_dv;
    logic [WORD_W-1:0]     goal256, err;

    assign goal_d_prod = goal_reg * d_reg;
    assign baud_prod   = base_reg * m_reg;
    assign dv1k        = dvq_reg - {18'd0, m_reg, 10'd0};
    assign dv          = dv1k[WORD_W-1:10];
    assign m_plus_dv   = {1'b0, m_reg} + {1'b0, dv[FRAC_W-1:0]};
    assign goal256     = {2'b00, goal_reg, 8'd0};
    assign err         = (baud_reg >= goal256) ? baud_reg - goal256 : goal256 - baud_reg;

    // Divisor bounds from q = pclk / goal.
    assign hi_raw = {1'b0, q_reg[WORD_W-1:4]} + 29'd1;
    assign hi_val = (hi_raw > {13'd0, DIVISOR_MAX}) ? DIVISOR_MAX : hi_raw[DIV_W-1:0];
    assign lo_raw = q_reg[WORD_W-1:8];
    assign lo_val = (lo_raw >= 24'd3) ? lo_raw - 24'd1 : 24'd2;

    always_comb
    begin
        unique case (cmd.div_sel)
            DS_Q:
            begin
                dvd = {4'd0, pclk_reg};
                dsr = {10'd0, goal_reg};
            end
            DS_FRAC:
            begin
                dvd = goal_d_prod[WORD_W-1:0];
                dsr = {18'd0, pclk_reg[PCLK_W-1:14]};
            end
            DS_BASE:
            begin
                dvd = {pclk_reg, 4'd0};
                dsr = {16'd0, d_reg};
            end
            DS_DV:
            begin
                dvd = {8'd0, m_reg, 20'd0} + {1'b0, frac_reg[21:0], 9'd0};
                dsr = frac_reg;
            end
            DS_BAUD:
            begin
                dvd = baud_prod[WORD_W-1:0];
                dsr = {27'd0, m_plus_dv};
            end
            default:
            begin
                dvd = '0;
                dsr = '0;
            end
        endcase
    end

    fbds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (dvd),
        .divisor  (dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pclk_reg      <= 28'd18000000;
            d_reg         <= '0;
            m_reg         <= '0;
            best_d_reg    <= '0;
            best_m_reg    <= '0;
            best_da_reg   <= '0;
            best_err_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                pclk_reg <= cfg_data;
            if (cmd.init)
            begin
                best_d_reg   <= '0;
                best_m_reg   <= '0;
                best_da_reg  <= '0;
                best_err_reg <= {1'b0, goal_in, 8'd0};
                found_reg    <= 1'b0;
            end
            else if (cmd.update_best)
            begin
                best_d_reg   <= d_reg;
                best_m_reg   <= m_reg;
                best_da_reg  <= dv[FRAC_W-1:0];
                best_err_reg <= err[BEST_ERR_W-1:0];
                found_reg    <= 1'b1;
            end
            if (cmd.set_bounds)
                d_reg <= lo_val[DIV_W-1:0];
            else if (cmd.next_d)
                d_reg <= d_reg + 16'd1;
            if (cmd.clr_m)
                m_reg <= '0;
            else if (cmd.next_m)
                m_reg <= m_reg + 4'd1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
            goal_reg <= goal_in;
        if (cmd.set_bounds)
            hi_reg <= hi_val;
        if (cmd.capture)
        begin
            unique case (cmd.div_sel)
                DS_Q:    q_reg    <= quo;
                DS_FRAC: frac_reg <= quo;
                DS_BASE: base_reg <= quo;
                DS_DV:   dvq_reg  <= quo;
                DS_BAUD: baud_reg <= quo;
                default: q_reg    <= quo;
            endcase
        end
        if (cmd.load_out)
        begin
            out_d_reg     <= best_d_reg;
            out_m_reg     <= best_m_reg;
            out_da_reg    <= best_da_reg;
            out_err_reg   <= found_reg ? best_err_reg[ERR_W-1:0] : '0;
            out_found_reg <= found_reg;
        end
    end

    always_comb
    begin
        stat.goal_zero = (goal_in == '0);
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.empty     = (lo_val > {8'd0, hi_val});
        stat.fden_zero = (pclk_reg[PCLK_W-1:14] == '0);
        stat.frac_zero = (frac_reg == '0);
        stat.dv_ok     = (dv >= {18'd0, DV_MIN}) && (dv <= {18'd0, FRAC_MAX});
        stat.better    = (err < {1'b0, best_err_reg});
        stat.d_last    = (d_reg == hi_reg);
        stat.m_last    = (m_reg == FRAC_MAX);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_divisor = out_d_reg;
    assign out_mul     = out_m_reg;
    assign out_dadd    = out_da_reg;
    assign out_err     = out_err_reg;
    assign out_found   = out_found_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |-> !div_busy)
        else $error("divider started while busy");
    a_capture_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> div_done)
        else $error("quotient captured without divider done");
    a_d_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_d |-> (d_reg < hi_reg))
        else $error("divisor stepped past upper bound");
    a_found_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update_best |=> found_reg)
        else $error("found flag not set after best update");
`endif

endmodule
`default_nettype wire

>>> sv/fbds_ctrl.sv
// Controller of the baud divisor search: one-hot state machine that
// sequences the divisions and the divisor/multiplier loops.
// Depends on fbds_pkg.
`default_nettype none
module fbds_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire fbds_pkg::fbds_stat_t stat,
    output fbds_pkg::fbds_cmd_t       cmd
);
    import fbds_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_QDIV    = 14'b00000000000010,
        S_BOUNDS  = 14'b00000000000100,
        S_DSTEP   = 14'b00000000001000,
        S_FDIV    = 14'b00000000010000,
        S_FCHK    = 14'b00000000100000,
        S_BDIV    = 14'b00000001000000,
        S_MSTART  = 14'b00000010000000,
        S_DVDIV   = 14'b00000100000000,
        S_CHECK   = 14'b00001000000000,
        S_BAUDDIV = 14'b00010000000000,
        S_CMP     = 14'b00100000000000,
        S_ADV     = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DS_Q;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.init = 1'b1;
                    if (stat.goal_zero)
                        state_next = S_DONE;
                    else
                        state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                // The divider start is issued here on entry, while the divider is neither busy nor done.
                cmd.div_sel   = DS_Q;
                cmd.start_div = !stat.div_busy && !stat.div_done;
                if (stat.div_done)
                begin
                    cmd.start_div = 1'b0;
                    cmd.capture   = 1'b1;
                    state_next    = S_BOUNDS;
                end
            end
            S_BOUNDS:
            begin
                if (stat.empty)
                    state_next = S_DONE;
                else
                begin
                    cmd.set_bounds = 1'b1;
                    state_next     = S_DSTEP;
                end
            end
            S_DSTEP:
            begin
                if (stat.fden_zero)
                begin
                    if (stat.d_last)
                        state_next = S_DONE;
                    else
                        cmd.next_d = 1'b1;
                end
                else
                begin
                    cmd.div_sel   = DS_FRAC;
                    cmd.start_div = 1'b1;
                    state_next    = S_FDIV;
                end
            end
            S_FDIV:
            begin
                cmd.div_sel = DS_FRAC;
                if (stat.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (stat.frac_zero)
                begin
                    if (stat.d_last)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_DSTEP;
                    end
                end
                else
                begin
                    cmd.div_sel   = DS_BASE;
                    cmd.start_div = 1'b1;
                    state_next    = S_BDIV;
                end
            end
            S_BDIV:
            begin
                cmd.div_sel = DS_BASE;
                if (stat.div_done)
                begin
                    cmd.capture = 1'b1;
                    cmd.clr_m   = 1'b1;
                    state_next  = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.div_sel   = DS_DV;
                cmd.start_div = 1'b1;
                state_next    = S_DVDIV;
            end
            S_DVDIV:
            begin
                cmd.div_sel = DS_DV;
                if (stat.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.dv_ok)
                begin
                    cmd.div_sel   = DS_BAUD;
                    cmd.start_div = 1'b1;
                    state_next    = S_BAUDDIV;
                end
                else
                    state_next = S_ADV;
            end
            S_BAUDDIV:
            begin
                cmd.div_sel = DS_BAUD;
                if (stat.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.update_best = stat.better;
                state_next      = S_ADV;
            end
            S_ADV:
            begin
                if (!stat.m_last)
                begin
                    cmd.next_m = 1'b1;
                    state_next = S_MSTART;
                end
                else if (stat.d_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.next_d = 1'b1;
                    state_next = S_DSTEP;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but search not started");
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == S_IDLE))
        else $error("result loaded outside the finish step");
    a_no_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_div && cmd.capture) |-> 1'b0)
        else $error("divider start and capture in one cycle");
`endif

endmodule
`default_nettype wire

>>> sv/fractional_baud_divisor_search_unit.sv
// Fractional baud divisor search unit: one result item per goal item.
// Sequence: a division for q, then per divisor a fraction division and, if the
// fraction is nonzero, a base division, plus per multiplier a divide-add division
// and a baud division when the divide-add is in range; all share the one divider. One item is searched at a time.
// Reset: asynchronous active-low; clock register returns to 18000000 Hz.
`default_nettype none
module fractional_baud_divisor_search_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    fbds_cfg_if.sink  cfg,
    fbds_req_if.sink  req,
    fbds_rsp_if.source rsp
);
    import fbds_pkg::*;

    fbds_cmd_t  cmd;
    fbds_stat_t stat;
    logic       req_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    fbds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbds_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .goal_in     (req.goal_baud),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_divisor (rsp.divisor_latch),
        .out_mul     (rsp.frac_multiplier),
        .out_dadd    (rsp.frac_divide_add),
        .out_err     (rsp.error_x256),
        .out_found   (rsp.found)
    );

endmodule
`default_nettype wire

>>> test/fbds_tb_checker.sv
`timescale 1ns / 100ps
// Checker for the fractional baud divisor search unit: watches the config,
// goal and result channels, predicts each result and compares it.
// Depends on fbds_pkg and the channel interfaces in fbds_if.sv.
module fbds_tb_checker
    import fbds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fbds_cfg_if  cfg,
    fbds_req_if  req,
    fbds_rsp_if  rsp,
    output int   fail_count,
    output int   awaited_count,
    output int   result_count
);

    typedef struct {
        logic [DIV_W-1:0]  divisor;
        logic [FRAC_W-1:0] mult;
        logic [FRAC_W-1:0] divide_add;
        logic [ERR_W-1:0]  error;
        logic              found;
    } baud_setting_t;

    baud_setting_t     awaited_settings[$];
    logic [PCLK_W-1:0] pclk_hz;

    assign awaited_count = awaited_settings.size();

    // Exhaustive search over divisor and multiplier, 32-bit truncating math.
    function automatic baud_setting_t best_baud_setting(bit [31:0] pclk, bit [31:0] goal);
        baud_setting_t best;
        bit [31:0] goal_x256, best_err, q, d_hi, d_lo, clk_div, frac, dv1k, dv;
        bit [31:0] baud, err, d, m;
        best = '{default: '0};
        goal_x256 = goal * 32'd256;
        best_err = goal_x256;
        if (goal != 0)
        begin
            q = pclk / goal;
            d_hi = q / 32'd16 + 32'd1;
            d_lo = q / 32'd256;
            d_lo = (d_lo >= 32'd3) ? d_lo - 32'd1 : 32'd2;
            if (d_hi > 32'(DIVISOR_MAX))
                d_hi = 32'(DIVISOR_MAX);
            clk_div = pclk >> 14;
            for (d = d_lo; d <= d_hi && clk_div != 0; d++)
            begin
                frac = (goal * d) / clk_div;
                if (frac == 0)
                    continue;
                for (m = 0; m <= 32'(FRAC_MAX); m++)
                begin
                    dv1k = (m * 32'd1048576 + ((frac * 32'd1024) >> 1)) / frac
                           - m * 32'd1024;
                    dv = dv1k / 32'd1024;
                    if (dv < 32'(DV_MIN) || dv > 32'(FRAC_MAX))
                        continue;
                    baud = (pclk * 32'd16) / d;
                    baud = (baud * m) / (m + dv);
                    err = (baud >= goal_x256) ? baud - goal_x256 : goal_x256 - baud;
                    if (err < best_err)
                    begin
                        best_err = err;
                        best.divisor = d[DIV_W-1:0];
                        best.mult = m[FRAC_W-1:0];
                        best.divide_add = dv[FRAC_W-1:0];
                        best.error = err[ERR_W-1:0];
                        best.found = 1'b1;
                    end
                end
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        baud_setting_t want;
        if (!rst_n)
        begin
            pclk_hz <= 28'd18000000;
            fail_count <= 0;
            result_count <= 0;
            awaited_settings.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                pclk_hz <= cfg.data;
            if (req.valid && req.ready)
                awaited_settings.push_back(best_baud_setting(32'(pclk_hz), 32'(req.goal_baud)));
            if (rsp.valid && rsp.ready)
            begin
                result_count <= result_count + 1;
                if (awaited_settings.size() == 0)
                begin
                    $display("%0t: unexpected result item, divisor %0d", $time,
                             rsp.divisor_latch);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_settings.pop_front();
                    if (want.divisor !== rsp.divisor_latch || want.mult !== rsp.frac_multiplier
                        || want.divide_add !== rsp.frac_divide_add
                        || want.error !== rsp.error_x256 || want.found !== rsp.found)
                    begin
                        $display("%0t: mismatch expected div %0d mul %0d add %0d err %0d found %0b",
                                 $time, want.divisor, want.mult, want.divide_add,
                                 want.error, want.found);
                        $display("%0t:          actual   div %0d mul %0d add %0d err %0d found %0b",
                                 $time, rsp.divisor_latch, rsp.frac_multiplier,
                                 rsp.frac_divide_add, rsp.error_x256, rsp.found);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_fractional_baud_divisor_search_unit.sv
`timescale 1ns / 100ps
// Testbench top for the fractional baud divisor search unit: drives clock
// settings and goal baud items, stalls the result side, gives the verdict.
// Depends on fbds_pkg, fbds_if.sv, fbds_tb_checker and the block itself.
module tb_fractional_baud_divisor_search_unit;
    import fbds_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int SETTLE_CYCLES = 200;

    logic clk;
    logic rst_n;
    int   fail_count, awaited_count, result_count;
    int   goals_sent;
    int   cycle_count;
    bit   quiet_phase;

    fbds_cfg_if cfg();
    fbds_req_if req();
    fbds_rsp_if rsp();

    fractional_baud_divisor_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    fbds_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .result_count  (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet_phase || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side stalls at random.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_goal(input logic [GOAL_W-1:0] goal);
        int gap;
        req.valid <= 1'b1;
        req.goal_baud <= goal;
        do
            @(negedge clk);
        while (!req.ready);
        @(posedge clk);
        goals_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The last goal item has just been taken, so valid drops before the
    // block can come back to idle.
    task automatic drain();
        req.valid <= 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic set_pclk(input logic [PCLK_W-1:0] hz);
        cfg.valid <= 1'b1;
        cfg.data <= hz;
        do
            @(negedge clk);
        while (!cfg.ready);
        @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Goal a few divisor steps away from the clock so the search stays short;
    // a few items go further out, some are fully random noise.
    function automatic logic [GOAL_W-1:0] pick_goal(input logic [PCLK_W-1:0] hz);
        int unsigned ratio, goal;
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            ratio = $urandom_range(400, 900);
        else
            ratio = $urandom_range(1, 400);
        goal = hz / ratio;
        if (roll >= 90)
        begin
            goal = $urandom_range(0, 4194303);
            if (goal != 0 && hz / goal > 900)
                goal = hz / 900 + 1;
        end
        if (goal > 4194303)
            goal = 4194303;
        return goal[GOAL_W-1:0];
    endfunction

    task automatic random_phase(input logic [PCLK_W-1:0] hz, input int count);
        set_pclk(hz);
        repeat (count) send_goal(pick_goal(hz));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        req.valid = 1'b0;
        req.goal_baud = '0;
        goals_sent = 0;
        quiet_phase = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset clock of 18 MHz: zero goal, empty divisor range, common rates.
        send_goal(22'd0);
        send_goal(22'd4194303);
        send_goal(22'd2250000);
        send_goal(22'd1125000);
        send_goal(22'd1058823);
        send_goal(22'd562500);
        send_goal(22'd115200);
        send_goal(22'd70312);
        drain();

        // Slowest clock: smallest nonzero fraction denominator.
        quiet_phase = 1'b1;
        set_pclk(28'd16384);
        send_goal(22'd64);
        send_goal(22'd100);
        send_goal(22'd1024);
        send_goal(22'd16384);
        send_goal(22'd3);
        drain();
        quiet_phase = 1'b0;

        // Fastest clock: largest goals, every goal bit high.
        set_pclk(28'd268435455);
        send_goal(22'd4194303);
        send_goal(22'd2097152);
        send_goal(22'd1048577);
        send_goal(22'd3145727);
        send_goal(22'd700001);
        drain();

        random_phase(28'd268435455, 20);
        random_phase(28'($urandom_range(16384, 268435455)), 20);
        random_phase(28'($urandom_range(16384, 1000000)), 20);
        quiet_phase = 1'b1;
        random_phase(28'd18000000, 10);
        quiet_phase = 1'b0;
        random_phase(28'($urandom_range(1000000, 268435455)), 20);

        $display("sent %0d goal items over several clock settings, %0d results checked",
                 goals_sent, result_count);
        $display("clock range 16384 Hz to 268435455 Hz, goals from zero to full scale");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
